/* hdl/abcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abcm_pkg: shared types and constants for the AES chaining-mode engine
// S-box tables, register indexes, mode codes, sequencer states, key-store layout.
// ----------------------------------------------------------------------------
package abcm_pkg;

	localparam int RK_ROWS = 15;
	localparam int RK_AW   = 4;
	localparam int ROW_W   = 128;

	localparam logic [2:0] REG_KEY_SIZE   = 3'd0;
	localparam logic [2:0] REG_CHAIN_MODE = 3'd1;
	localparam logic [2:0] REG_DIRECTION  = 3'd2;
	localparam logic [2:0] REG_KEY_WORD0  = 3'd3;
	localparam logic [2:0] REG_KEY_WORD1  = 3'd4;
	localparam logic [2:0] REG_KEY_WORD2  = 3'd5;
	localparam logic [2:0] REG_KEY_WORD3  = 3'd6;

	localparam logic [2:0] MODE_ECB = 3'd0;
	localparam logic [2:0] MODE_CBC = 3'd1;
	localparam logic [2:0] MODE_CFB = 3'd2;
	localparam logic [2:0] MODE_OFB = 3'd3;
	localparam logic [2:0] MODE_CTR = 3'd4;

	localparam logic [1:0] KS_192 = 2'd1;
	localparam logic [1:0] KS_256 = 2'd2;

	localparam logic ACT_LOAD = 1'b1;

	typedef enum logic [2:0] {
		ST_KEXP,
		ST_IDLE,
		ST_ARK,
		ST_ROUND,
		ST_DONE
	} fsm_t;

	typedef struct packed {
		logic             en;
		logic [RK_AW-1:0] addr;
		logic [ROW_W-1:0] data;
	} rk_wr_t;

	localparam logic [2047:0] SBOX_TBL = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [2047:0] ISBOX_TBL = {
		128'h52096ad53036a538bf40a39e81f3d7fb,
		128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e,
		128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692,
		128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506,
		128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673,
		128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b,
		128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f,
		128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961,
		128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX_TBL[11'd2047 - {b, 3'b000} -: 8];
	endfunction

	function automatic logic [7:0] isbox(input logic [7:0] b);
		return ISBOX_TBL[11'd2047 - {b, 3'b000} -: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [3:0] round_count(input logic [1:0] ks);
		logic [3:0] nr;
		nr = 4'd10;
		if (ks == KS_192) nr = 4'd12;
		else if (ks == KS_256) nr = 4'd14;
		return nr;
	endfunction

endpackage
`default_nettype wire

/* hdl/abcm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abcm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module abcm_ram #(
	parameter int WIDTH = abcm_pkg::ROW_W,
	parameter int DEPTH = abcm_pkg::RK_ROWS
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hdl/abcm_key_exp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abcm_key_exp: key schedule sequencer
// Produces one schedule word per cycle and writes each full 4-word row to the store.
// ----------------------------------------------------------------------------
module abcm_key_exp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     key_size,
	input  wire logic [255:0]   key,
	output logic                busy,
	output abcm_pkg::rk_wr_t    rk_wr
);
	import abcm_pkg::*;

	logic        busy_q;
	logic [5:0]  i_q;
	logic [2:0]  j_q;
	logic [7:0]  rc_q;
	logic [31:0] win_q [8];
	logic [95:0] rowbuf_q;

	logic [2:0]  nk_m1;
	logic [5:0]  last_idx;
	logic [31:0] t, w, back;
	logic        is_key, rot_step;

	always_comb begin
		nk_m1    = 3'd3;
		last_idx = 6'd43;
		back     = win_q[3];
		if (key_size == KS_192) begin
			nk_m1    = 3'd5;
			last_idx = 6'd51;
			back     = win_q[5];
		end else if (key_size == KS_256) begin
			nk_m1    = 3'd7;
			last_idx = 6'd59;
			back     = win_q[7];
		end
		is_key   = (i_q <= {3'd0, nk_m1});
		rot_step = !is_key && (j_q == 3'd0);
		t = win_q[0];
		if (rot_step) begin
			t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
			    ^ {rc_q, 24'd0};
		end else if (!is_key && nk_m1 == 3'd7 && j_q == 3'd4) begin
			t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
		end
		if (is_key) w = key[9'd255 - {i_q[2:0], 5'd0} -: 32];
		else        w = back ^ t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			i_q    <= '0;
			j_q    <= '0;
			rc_q   <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
			j_q    <= '0;
			rc_q   <= 8'h01;
		end else if (busy_q) begin
			i_q <= i_q + 6'd1;
			j_q <= (j_q == nk_m1) ? 3'd0 : j_q + 3'd1;
			if (rot_step) rc_q <= xt(rc_q);
			if (i_q == last_idx) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			win_q[0] <= w;
			for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
			rowbuf_q <= {rowbuf_q[63:0], w};
		end
	end

	assign busy       = busy_q;
	assign rk_wr.en   = busy_q && !start && (i_q[1:0] == 2'd3);
	assign rk_wr.addr = i_q[5:2];
	assign rk_wr.data = {rowbuf_q, w};

endmodule
`default_nettype wire

/* hdl/abcm_round.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abcm_round: one AES round, forward or inverse
// Combinational round function shared by every round of a block.
// ----------------------------------------------------------------------------
module abcm_round (
	input  wire logic [127:0] blk,
	input  wire logic [127:0] rk,
	input  wire logic         dec,
	input  wire logic         last,
	output logic      [127:0] nxt
);
	import abcm_pkg::*;

	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		for (int k = 0; k < 16; k++)
			o[127-8*k -: 8] = inv ? isbox(s[127-8*k -: 8]) : sbox(s[127-8*k -: 8]);
		return o;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (inv) o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
				else     o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
			end
		return o;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		logic [7:0] a, b, d, e, all;
		logic [7:0] a2, b2, d2, e2, a4, b4, d4, e4, a8, b8, d8, e8;
		for (int c = 0; c < 4; c++) begin
			a = s[127-32*c -: 8];
			b = s[119-32*c -: 8];
			d = s[111-32*c -: 8];
			e = s[103-32*c -: 8];
			if (!inv) begin
				all = a ^ b ^ d ^ e;
				o[127-32*c -: 8] = a ^ all ^ xt(a ^ b);
				o[119-32*c -: 8] = b ^ all ^ xt(b ^ d);
				o[111-32*c -: 8] = d ^ all ^ xt(d ^ e);
				o[103-32*c -: 8] = e ^ all ^ xt(e ^ a);
			end else begin
				a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
				b2 = xt(b); b4 = xt(b2); b8 = xt(b4);
				d2 = xt(d); d4 = xt(d2); d8 = xt(d4);
				e2 = xt(e); e4 = xt(e2); e8 = xt(e4);
				// 0e = 8^4^2, 0b = 8^2^1, 0d = 8^4^1, 09 = 8^1
				o[127-32*c -: 8] = (a8^a4^a2) ^ (b8^b2^b) ^ (d8^d4^d) ^ (e8^e);
				o[119-32*c -: 8] = (a8^a) ^ (b8^b4^b2) ^ (d8^d2^d) ^ (e8^e4^e);
				o[111-32*c -: 8] = (a8^a4^a) ^ (b8^b) ^ (d8^d4^d2) ^ (e8^e2^e);
				o[103-32*c -: 8] = (a8^a2^a) ^ (b8^b4^b) ^ (d8^d) ^ (e8^e4^e2);
			end
		end
		return o;
	endfunction

	logic [127:0] fwd, inv_k;

	always_comb begin
		fwd = shift_rows(sub_bytes(blk, 1'b0), 1'b0);
		if (!last) fwd = mix_cols(fwd, 1'b0);
		inv_k = sub_bytes(shift_rows(blk, 1'b1), 1'b1) ^ rk;
		if (dec) nxt = last ? inv_k : mix_cols(inv_k, 1'b1);
		else     nxt = fwd ^ rk;
	end

endmodule
`default_nettype wire

/* hdl/aes_block_cipher_modes.sv */
// A data item is taken in idle, then runs the add-round-key state, Nr round states
// (10, 12 or 14 for 128, 192 and 256 bit keys) and the done state; a load item only
// sets the chaining value. One round runs per cycle in the shared round unit; no new
// item is taken until the engine is back in idle. A key or key-size write rebuilds the
// key store one word a cycle (44, 52 or 60 words). Reset clears the state, config and
// chaining registers, builds the all-zero AES-128 schedule and holds off configuration.
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_cipher_modes: AES-128/192/256 engine with ECB, CBC, CFB, OFB, CTR
// Config registers, sequencer, chaining logic and output register.
// ----------------------------------------------------------------------------
module aes_block_cipher_modes (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // [63:0] data_hi, [127:64] data_lo
	input  wire logic         s_tuser,   // [0] action
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata    // [63:0] result_hi, [127:64] result_lo
);
	import abcm_pkg::*;

	fsm_t state_q, state_d;

	logic [1:0]   key_size_q;
	logic [2:0]   chain_mode_q;
	logic         direction_q;
	logic [255:0] key_q;
	logic [127:0] chain_q;
	logic [127:0] blk_q, x_q;
	logic [3:0]   rnd_q;
	logic [RK_AW-1:0] kidx_q, kidx_d;
	logic         m_tvalid_q;
	logic [127:0] m_tdata_q;

	logic cfg_we, in_acc, rekey, blk_start, done_go;
	logic [3:0] nr;
	logic mode_ok, dec_eff, last_rnd;
	logic [127:0] x_in, pre, rk, nxt, y, v_next;
	logic kx_busy;
	rk_wr_t rk_wr;

	assign nr       = round_count(key_size_q);
	assign mode_ok  = (chain_mode_q <= MODE_CTR);
	assign dec_eff  = direction_q && (chain_mode_q == MODE_ECB || chain_mode_q == MODE_CBC);
	assign last_rnd = (rnd_q == nr);
	assign x_in     = {s_tdata[63:0], s_tdata[127:64]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_KEXP:  if (!kx_busy) state_d = ST_IDLE;
			ST_IDLE: begin
				if (rekey) state_d = ST_KEXP;
				else if (blk_start) state_d = ST_ARK;
			end
			ST_ARK:   state_d = ST_ROUND;
			ST_ROUND: if (last_rnd) state_d = ST_DONE;
			ST_DONE:  if (done_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cfg_ready = 1'b0;
		s_tready  = 1'b0;
		done_go   = 1'b0;
		kidx_d    = kidx_q;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				s_tready  = !cfg_valid;
				if (blk_start) kidx_d = dec_eff ? nr : '0;
			end
			ST_ARK:   kidx_d = dec_eff ? kidx_q - 1'b1 : kidx_q + 1'b1;
			ST_ROUND: if (!last_rnd) kidx_d = dec_eff ? kidx_q - 1'b1 : kidx_q + 1'b1;
			ST_DONE:  done_go = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_acc    = s_tvalid && s_tready;
	assign rekey     = cfg_we && (cfg_index == REG_KEY_SIZE || cfg_index == REG_KEY_WORD0 ||
	                   cfg_index == REG_KEY_WORD1 || cfg_index == REG_KEY_WORD2 ||
	                   cfg_index == REG_KEY_WORD3);
	assign blk_start = in_acc && (s_tuser != ACT_LOAD) && mode_ok;

	always_comb begin
		priority case (chain_mode_q)
			MODE_ECB: pre = x_in;
			MODE_CBC: pre = direction_q ? x_in : x_in ^ chain_q;
			default:  pre = chain_q;
		endcase
	end

	abcm_key_exp u_key_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rekey),
		.key_size (key_size_q),
		.key      (key_q),
		.busy     (kx_busy),
		.rk_wr    (rk_wr)
	);

	abcm_ram #(
		.WIDTH (ROW_W),
		.DEPTH (RK_ROWS)
	) u_rk_ram (
		.clk   (clk),
		.we    (rk_wr.en),
		.waddr (rk_wr.addr),
		.wdata (rk_wr.data),
		.raddr (kidx_d),
		.rdata (rk)
	);

	abcm_round u_round (
		.blk  (blk_q),
		.rk   (rk),
		.dec  (dec_eff),
		.last (last_rnd),
		.nxt  (nxt)
	);

	// result and chaining update
	always_comb begin
		y      = x_q ^ blk_q;
		v_next = chain_q;
		unique case (chain_mode_q)
			MODE_ECB: y = blk_q;
			MODE_CBC: begin
				if (direction_q) begin
					y      = blk_q ^ chain_q;
					v_next = x_q;
				end else begin
					y      = blk_q;
					v_next = blk_q;
				end
			end
			MODE_CFB: v_next = direction_q ? x_q : x_q ^ blk_q;
			MODE_OFB: v_next = blk_q;
			MODE_CTR: v_next = chain_q + 128'd1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_KEXP;
			key_size_q   <= '0;
			chain_mode_q <= '0;
			direction_q  <= 1'b0;
			key_q        <= '0;
			chain_q      <= '0;
			m_tvalid_q   <= 1'b0;
			rnd_q        <= '0;
			kidx_q       <= '0;
		end else begin
			state_q <= state_d;
			kidx_q  <= kidx_d;
			if (cfg_we) begin
				priority case (cfg_index)
					REG_KEY_SIZE:   key_size_q   <= cfg_data[1:0];
					REG_CHAIN_MODE: chain_mode_q <= cfg_data[2:0];
					REG_DIRECTION:  direction_q  <= cfg_data[0];
					REG_KEY_WORD0:  key_q[255:192] <= cfg_data;
					REG_KEY_WORD1:  key_q[191:128] <= cfg_data;
					REG_KEY_WORD2:  key_q[127:64]  <= cfg_data;
					REG_KEY_WORD3:  key_q[63:0]    <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc && s_tuser == ACT_LOAD) chain_q <= x_in;
			if (state_q == ST_ARK) rnd_q <= 4'd1;
			else if (state_q == ST_ROUND) rnd_q <= rnd_q + 4'd1;
			if (done_go) begin
				chain_q    <= v_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_start) begin
			blk_q <= pre;
			x_q   <= x_in;
		end else if (state_q == ST_ARK) begin
			blk_q <= blk_q ^ rk;
		end else if (state_q == ST_ROUND) begin
			blk_q <= nxt;
		end
		if (done_go) m_tdata_q <= {y[63:0], y[127:64]};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

/* hdl/abcm_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abcm_checker: port-level checks for the AES chaining-mode engine
// Watches handshakes and busy behavior; bound to the top level.
// ----------------------------------------------------------------------------
module abcm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         cfg_valid,
	input wire logic         cfg_ready,
	input wire logic [2:0]   cfg_index,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata
);
	import abcm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_rekey_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_KEY_SIZE ||
		cfg_index == REG_KEY_WORD0 || cfg_index == REG_KEY_WORD1 ||
		cfg_index == REG_KEY_WORD2 || cfg_index == REG_KEY_WORD3)
		|=> !s_tready && !cfg_ready)
		else $error("item taken during key expansion");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> cfg_ready)
		else $error("input ready outside idle");

endmodule

bind aes_block_cipher_modes abcm_checker u_abcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
`default_nettype wire
